[design/bdc_pkg.sv]
package bdc_pkg;

   localparam int MAX_TOTAL = 1023;
   localparam int ROW_LEN   = MAX_TOTAL + 1;
   localparam int IDX_W     = $clog2(ROW_LEN);
   localparam int ADDR_W    = IDX_W + 1;
   localparam int MEM_DEPTH = 2 * ROW_LEN;
   localparam int LIMIT_W   = 16;
   localparam int CSR_W     = 10;
   localparam int WAYS_W    = 30;

   localparam logic [WAYS_W-1:0] WAYS_MOD = 30'd1000000007;
   localparam logic [WAYS_W-1:0] WAYS_ONE = 30'd1;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [WAYS_W-1:0] ways_type;

   // one row step travelling down the pipe
   typedef struct packed {
      logic    valid;
      logic    fresh;
      logic    use_lo;
      logic    head;
      logic    last;
      logic    dst_bank;
      idx_type idx;
   } step_ctrl_type;

   typedef struct packed {
      logic     en;
      addr_type addr;
      ways_type data;
   } mem_wr_type;

   function automatic idx_type sat_total(input logic [CSR_W-1:0] total);
      idx_type k;
      if (int'(total) > MAX_TOTAL) begin
         k = idx_type'(MAX_TOTAL);
      end else begin
         k = idx_type'(total);
      end
      return k;
   endfunction

endpackage

[design/bdc_req_if.sv]
interface bdc_req_if;
   logic                        valid;
   logic                        ready;
   logic [bdc_pkg::LIMIT_W-1:0] limit;
   logic                        first;

   modport source (output valid, output limit, output first, input ready);
   modport sink   (input valid, input limit, input first, output ready);
endinterface

[design/bdc_rsp_if.sv]
interface bdc_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [bdc_pkg::WAYS_W-1:0] ways;

   modport source (output valid, output ways, input ready);
   modport sink   (input valid, input ways, output ready);
endinterface

[design/bdc_row_mem.sv]
module bdc_row_mem (
   input  logic                 clock,
   input  bdc_pkg::mem_wr_type  wr,
   input  bdc_pkg::addr_type    rd_addr_hi,
   input  bdc_pkg::addr_type    rd_addr_lo,
   output bdc_pkg::ways_type    rd_data_hi,
   output bdc_pkg::ways_type    rd_data_lo
);

   bdc_pkg::ways_type mem [bdc_pkg::MEM_DEPTH];
   bdc_pkg::ways_type rd_hi_ff;
   bdc_pkg::ways_type rd_lo_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_hi_ff <= mem[rd_addr_hi];
      rd_lo_ff <= mem[rd_addr_lo];
   end

   assign rd_data_hi = rd_hi_ff;
   assign rd_data_lo = rd_lo_ff;

endmodule

[design/bdc_mod_acc.sv]
module bdc_mod_acc (
   input  logic                   clock,
   input  logic                   reset,
   input  bdc_pkg::step_ctrl_type s1_ctrl,
   input  bdc_pkg::ways_type      rd_data_hi,
   input  bdc_pkg::ways_type      rd_data_lo,
   output bdc_pkg::mem_wr_type    wr,
   output logic                   done,
   output bdc_pkg::ways_type      result
);

   bdc_pkg::step_ctrl_type s2_ctrl_ff;
   bdc_pkg::ways_type      d_ff;
   bdc_pkg::ways_type      d_in;
   bdc_pkg::ways_type      run_ff;
   bdc_pkg::ways_type      run_in;
   bdc_pkg::ways_type      hi;
   bdc_pkg::ways_type      lo;
   bdc_pkg::ways_type      base;
   logic [bdc_pkg::WAYS_W:0] sum;

   // windowed difference
   always_comb begin
      hi = s1_ctrl.fresh ? bdc_pkg::WAYS_ONE : rd_data_hi;
      lo = '0;
      if (s1_ctrl.use_lo) begin
         lo = s1_ctrl.fresh ? bdc_pkg::WAYS_ONE : rd_data_lo;
      end
      if (hi >= lo) begin
         d_in = hi - lo;
      end else begin
         d_in = hi + (bdc_pkg::WAYS_MOD - lo);
      end
   end

   // running prefix sum
   always_comb begin
      base = s2_ctrl_ff.head ? '0 : run_ff;
      sum  = {1'b0, base} + {1'b0, d_ff};
      if (sum >= {1'b0, bdc_pkg::WAYS_MOD}) begin
         run_in = bdc_pkg::ways_type'(sum - {1'b0, bdc_pkg::WAYS_MOD});
      end else begin
         run_in = sum[bdc_pkg::WAYS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctrl_ff <= '0;
      end else begin
         s2_ctrl_ff <= s1_ctrl;
      end
   end

   always_ff @(posedge clock) begin
      d_ff <= d_in;
      if (s2_ctrl_ff.valid) begin
         run_ff <= run_in;
      end
   end

   assign wr.en   = s2_ctrl_ff.valid;
   assign wr.addr = {s2_ctrl_ff.dst_bank, s2_ctrl_ff.idx};
   assign wr.data = run_in;
   assign done    = s2_ctrl_ff.valid & s2_ctrl_ff.last;
   assign result  = d_ff;

endmodule

[design/bounded_distribution_counter.sv]
// Counts, modulo 1000000007, the ways to share exactly total_units units among the
// recipients of the current set, each taking 0..limit. Write total_units through
// csr_wr_en/csr_wr_data while idle; values above 1023 saturate. Each req transfer
// carries one recipient (first = 1 opens a new set) and yields one rsp transfer.
// The prefix row lives in a two-bank RAM with two read ports and one write port;
// each item walks the row one entry per cycle and occupies the block through the
// row walk, two arithmetic stages and the result load. A new request is taken while
// the previous result still waits on rsp. The RAM needs no clearing after reset.
module bounded_distribution_counter (
   input  logic                        clock,
   input  logic                        reset,
   bdc_req_if.sink                     req_ch,
   bdc_rsp_if.source                   rsp_ch,
   input  logic                        csr_wr_en,
   input  logic [bdc_pkg::CSR_W-1:0]   csr_wr_data
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_FLUSH = 2'd3;

   logic [1:0]                  state_ff, state_in;
   logic [bdc_pkg::CSR_W-1:0]   total_ff;
   logic [bdc_pkg::LIMIT_W-1:0] lim_ff;
   logic                        fresh_ff;
   bdc_pkg::idx_type            k_ff;
   bdc_pkg::idx_type            j_ff, j_in;
   logic                        row_bank_ff, row_bank_in;
   logic                        have_group_ff, have_group_in;
   bdc_pkg::ways_type           res_ff;
   bdc_pkg::ways_type           rsp_ways_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        req_xfer;
   logic                        rsp_load;

   bdc_pkg::step_ctrl_type      issue_ctrl;
   bdc_pkg::step_ctrl_type      s1_ctrl_ff;
   bdc_pkg::addr_type           rd_addr_hi;
   bdc_pkg::addr_type           rd_addr_lo;
   bdc_pkg::ways_type           rd_data_hi;
   bdc_pkg::ways_type           rd_data_lo;
   bdc_pkg::mem_wr_type         wr;
   logic                        acc_done;
   bdc_pkg::ways_type           acc_result;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_xfer     = req_ch.valid & req_ch.ready;
   assign rsp_load     = (state_ff == ST_FLUSH) & (~rsp_valid_ff | rsp_ch.ready);

   always_comb begin
      issue_ctrl.valid    = (state_ff == ST_ISSUE);
      issue_ctrl.fresh    = fresh_ff;
      issue_ctrl.use_lo   = {{(bdc_pkg::LIMIT_W-bdc_pkg::IDX_W){1'b0}}, j_ff} > lim_ff;
      issue_ctrl.head     = (j_ff == '0);
      issue_ctrl.last     = (j_ff == k_ff);
      issue_ctrl.dst_bank = ~row_bank_ff;
      issue_ctrl.idx      = j_ff;
      rd_addr_hi = {row_bank_ff, j_ff};
      rd_addr_lo = {row_bank_ff, j_ff - lim_ff[bdc_pkg::IDX_W-1:0] - bdc_pkg::idx_type'(1)};
   end

   always_comb begin
      state_in      = state_ff;
      j_in          = j_ff;
      row_bank_in   = row_bank_ff;
      have_group_in = have_group_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_ISSUE;
               j_in     = '0;
            end
         end
         ST_ISSUE: begin
            j_in = j_ff + bdc_pkg::idx_type'(1);
            if (j_ff == k_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (acc_done) begin
               state_in      = ST_FLUSH;
               row_bank_in   = ~row_bank_ff;
               have_group_in = 1'b1;
            end
         end
         ST_FLUSH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         j_ff          <= '0;
         row_bank_ff   <= 1'b0;
         have_group_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         total_ff      <= '0;
         s1_ctrl_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         j_ff          <= j_in;
         row_bank_ff   <= row_bank_in;
         have_group_ff <= have_group_in;
         rsp_valid_ff  <= rsp_valid_in;
         s1_ctrl_ff    <= issue_ctrl;
         if (csr_wr_en) begin
            total_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         lim_ff   <= req_ch.limit;
         fresh_ff <= req_ch.first | ~have_group_ff;
         k_ff     <= bdc_pkg::sat_total(total_ff);
      end
      if (acc_done) begin
         res_ff <= acc_result;
      end
      if (rsp_load) begin
         rsp_ways_ff <= res_ff;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.ways  = rsp_ways_ff;

   bdc_row_mem u_row_mem (
      .clock      (clock),
      .wr         (wr),
      .rd_addr_hi (rd_addr_hi),
      .rd_addr_lo (rd_addr_lo),
      .rd_data_hi (rd_data_hi),
      .rd_data_lo (rd_data_lo)
   );

   bdc_mod_acc u_mod_acc (
      .clock      (clock),
      .reset      (reset),
      .s1_ctrl    (s1_ctrl_ff),
      .rd_data_hi (rd_data_hi),
      .rd_data_lo (rd_data_lo),
      .wr         (wr),
      .done       (acc_done),
      .result     (acc_result)
   );

`ifndef SYNTHESIS
   // the row being built never lands in the bank being read
   a_wr_bank: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> (wr.addr[bdc_pkg::ADDR_W-1] != row_bank_ff))
      else $error("row write hits source bank");

   a_done_drain: assert property (@(posedge clock) disable iff (reset)
      acc_done |-> (state_ff == ST_DRAIN))
      else $error("row walk finished outside drain");

   a_xfer_issue: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == ST_ISSUE) && (j_ff == '0))
      else $error("request transfer did not start a row walk");

   a_ways_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ways_ff < bdc_pkg::WAYS_MOD))
      else $error("result not reduced");
`endif

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;

   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int TAIL_CYCLES = 1100;
   localparam int HOLD_OFF    = 300;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_mode_type;
   typedef logic [bdc_pkg::LIMIT_W-1:0] limit_type;
   typedef logic [bdc_pkg::CSR_W-1:0]   csr_type;

   class distribution_ledger;
      bdc_pkg::ways_type prefix_row [2][bdc_pkg::ROW_LEN];
      bit                bank;
      bit                have_set;
      csr_type           total = '0;
      bdc_pkg::ways_type expected_ways [$];
      int                errors;

      function void set_total(csr_type value);
         total = value;
      endfunction

      function int pending();
         return expected_ways.size();
      endfunction

      // one recipient folds into the row of prefix sums
      function void note_recipient(limit_type lim, logic first);
         int unsigned k, j, hi, lo, d, run, modv;
         bit src, dst, fresh;
         modv = 32'(bdc_pkg::WAYS_MOD);
         k = 32'(total);
         if (k > bdc_pkg::MAX_TOTAL) k = bdc_pkg::MAX_TOTAL;
         fresh = first || !have_set;
         src = bank;
         dst = ~src;
         run = 0;
         d = 0;
         for (j = 0; j <= k; j++) begin
            hi = fresh ? 1 : prefix_row[src][j];
            lo = 0;
            if (j > lim) lo = fresh ? 1 : prefix_row[src][j - lim - 1];
            d = (hi + modv - lo) % modv;
            run = (run + d) % modv;
            prefix_row[dst][j] = bdc_pkg::ways_type'(run);
         end
         bank = dst;
         have_set = 1'b1;
         expected_ways.push_back(bdc_pkg::ways_type'(d));
      endfunction

      task report(string what);
         $display("mismatch: %s", what);
         errors++;
      endtask

      task check_ways(bdc_pkg::ways_type got);
         bdc_pkg::ways_type want;
         if (expected_ways.size() == 0) begin
            report($sformatf("result with none expected, ways=%0d", got));
         end else begin
            want = expected_ways.pop_front();
            if (got !== want) report($sformatf("ways=%0d, expected %0d", got, want));
         end
      endtask

      task check_leftover();
         if (expected_ways.size() != 0)
            report($sformatf("%0d results never arrived", expected_ways.size()));
      endtask
   endclass

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   csr_type          csr_wr_data;
   int               send_idle_pct;
   int               rsp_stall_pct;
   int               hold_cycles;
   int               cycle_count;

   distribution_ledger ledger = new;

   bdc_req_if req_bus ();
   bdc_rsp_if rsp_bus ();

   bounded_distribution_counter u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("testbench: done, errors");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en) ledger.set_total(csr_wr_data);
         if (rsp_bus.valid && rsp_bus.ready) ledger.check_ways(rsp_bus.ways);
         if (req_bus.valid && req_bus.ready) ledger.note_recipient(req_bus.limit, req_bus.first);
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_cycles = hold_cycles - 1;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   task automatic set_idling(idling_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 82;
            rsp_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;
            rsp_stall_pct = 82;
         end
         default: begin
            send_idle_pct = 21;
            rsp_stall_pct = 21;
         end
      endcase
   endtask

   task automatic write_total(csr_type value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_item(limit_type lim, logic first);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.limit <= lim;
      req_bus.first <= first;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      int               p, i, r, n;
      csr_type          tot;
      limit_type        lim;
      logic             fst;

      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      req_bus.valid = 1'b0;
      req_bus.limit = '0;
      req_bus.first = 1'b0;
      hold_cycles   = 0;
      set_idling(IDLE_NONE);
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // full-width total: first transfer opens a set without the flag, fills both banks
      write_total(10'd1023);
      send_item(16'hFFFF, 1'b0);
      send_item(16'h0000, 1'b0);
      send_item(16'd1023, 1'b0);
      send_item(16'd1022, 1'b0);
      send_item(16'h8000, 1'b0);
      send_item(16'h7FFF, 1'b1);
      drain();

      write_total(10'd0);
      send_item(16'h0000, 1'b1);
      send_item(16'hFFFF, 1'b0);
      send_item(16'd5, 1'b0);
      drain();

      // total changed within a set
      write_total(10'd1);
      send_item(16'h0000, 1'b0);
      send_item(16'd1, 1'b0);
      send_item(16'hAAAA, 1'b1);
      send_item(16'h5555, 1'b0);
      drain();

      write_total(10'd10);
      send_item(16'd3, 1'b1);
      send_item(16'd3, 1'b0);
      send_item(16'd3, 1'b0);
      send_item(16'd10, 1'b0);
      send_item(16'd9, 1'b0);
      send_item(16'd11, 1'b0);
      drain();

      write_total(10'd512);
      send_item(16'd100, 1'b1);
      send_item(16'd511, 1'b0);
      send_item(16'd512, 1'b0);
      drain();

      for (p = 0; p < 28; p++) begin
         r = $urandom_range(0, 9);
         case (r)
            0: tot = 10'd1023;
            1: tot = csr_type'($urandom_range(0, 1023));
            2: tot = 10'd0;
            default: tot = csr_type'($urandom_range(1, 48));
         endcase
         n = (tot > 64) ? 4 : 20;
         set_idling(idling_mode_type'(p % 4));
         write_total(tot);
         for (i = 0; i < n; i++) begin
            if (i == 0) fst = ($urandom_range(0, 3) != 0);
            else fst = ($urandom_range(0, 9) == 0);
            r = $urandom_range(0, 9);
            if (r < 5) lim = limit_type'($urandom_range(0, int'(tot) + 2));
            else if (r < 7) lim = limit_type'($urandom_range(0, 3));
            else if (r == 7) lim = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            else lim = limit_type'($urandom());
            send_item(lim, fst);
         end
         drain();
      end

      // receiver holds off while the sender keeps offering
      set_idling(IDLE_NONE);
      tot = csr_type'($urandom_range(0, 8));
      write_total(tot);
      @(posedge clock);
      hold_cycles = HOLD_OFF;
      @(negedge clock);
      for (i = 0; i < 30; i++) begin
         lim = limit_type'($urandom_range(0, int'(tot) + 2));
         send_item(lim, (i == 0) || ($urandom_range(0, 9) == 0));
      end
      drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      ledger.check_leftover();
      if (ledger.errors == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

[bounded_distribution_counter.f]
design/bdc_pkg.sv
design/bdc_req_if.sv
design/bdc_rsp_if.sv
design/bdc_row_mem.sv
design/bdc_mod_acc.sv
design/bounded_distribution_counter.sv
test/testbench.sv
